FILE: sv/qapm_pkg.sv
`default_nettype none

package qapm_pkg;

  // Fixed-point format of angles and gains
  localparam int FRAC_BITS = 8;
  localparam int ONE       = 1 << FRAC_BITS;

  // Datapath widths
  localparam int ANG_W  = 16;
  localparam int GAIN_W = 16;
  localparam int THR_W  = 7;
  localparam int DT_W   = 16;
  localparam int MOT_W  = 7;
  localparam int ERR_W  = 17;
  localparam int DIFF_W = 18;
  localparam int INT_W  = 32;
  localparam int RATE_W = 28;
  localparam int MA_W   = 17;
  localparam int MB_W   = 28;
  localparam int MP_W   = MA_W + MB_W;
  localparam int ACC_W  = MP_W + 1;
  localparam int PID_W  = FRAC_BITS + 10;
  localparam int MIX_W  = FRAC_BITS + 14;
  localparam int DIV_NW = 27;
  localparam int DIV_DW = DT_W;
  localparam int DIV_CW = $clog2(DIV_NW + 1);
  localparam int PWM_W  = 11;

  // Control constants
  localparam int THR_MIN    = 15;
  localparam int IZONE      = 3 * ONE;
  localparam int RATE_SCALE = 1000;
  localparam int PID_MAX    = 400 * ONE;
  localparam int BASE_INT   = 115 + 1000;
  localparam int THR_GAIN   = 10;
  localparam int MOT_LO     = 1100 * ONE;
  localparam int MOT_HI     = 2000 * ONE;
  localparam int PWM_ZERO   = 1000;
  localparam int MOT_OFS    = 20;
  // floor(2*v/25) == (2*v * RECIP) >> RECIP_SH for 2*v <= 2000
  localparam int RECIP      = 2622;
  localparam int RECIP_SH   = 16;

  // Register reset values
  localparam int GAIN_P_RESET = 128;
  localparam int GAIN_I_RESET = 0;
  localparam int GAIN_D_RESET = 256;

  // Register map
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_GAIN_P_X = 3'd2,
    REG_GAIN_I_X = 3'd3,
    REG_GAIN_D_X = 3'd4,
    REG_GAIN_P_Y = 3'd5,
    REG_GAIN_I_Y = 3'd6,
    REG_GAIN_D_Y = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] offset_x;
    logic signed [ANG_W-1:0] offset_y;
    logic [GAIN_W-1:0]       gain_p_x;
    logic [GAIN_W-1:0]       gain_i_x;
    logic [GAIN_W-1:0]       gain_d_x;
    logic [GAIN_W-1:0]       gain_p_y;
    logic [GAIN_W-1:0]       gain_i_y;
    logic [GAIN_W-1:0]       gain_d_y;
  } cfg_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] measured_angle_x;
    logic signed [ANG_W-1:0] measured_angle_y;
    logic signed [ANG_W-1:0] desired_angle_x;
    logic signed [ANG_W-1:0] desired_angle_y;
    logic [THR_W-1:0]        throttle;
    logic [DT_W-1:0]         elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [MOT_W-1:0]        motor_left_front;
    logic [MOT_W-1:0]        motor_right_front;
    logic [MOT_W-1:0]        motor_right_back;
    logic [MOT_W-1:0]        motor_left_back;
    logic signed [ANG_W-1:0] corrected_angle_x;
    logic signed [ANG_W-1:0] corrected_angle_y;
  } out_item_t;

  // Divider request / response
  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  // Drop FRAC_BITS, rounding toward zero
  function automatic logic signed [MP_W-1:0] trunc_q(input logic signed [MP_W-1:0] v);
    logic signed [MP_W-1:0] bias;
    bias = v[MP_W-1] ? MP_W'(ONE - 1) : '0;
    return (v + bias) >>> FRAC_BITS;
  endfunction

endpackage

`default_nettype wire

FILE: sv/qapm_mul.sv
`default_nettype none

// Shared signed multiplier, product registered
module qapm_mul (
  input  wire logic                           clk,
  input  wire logic signed [qapm_pkg::MA_W-1:0] a,
  input  wire logic signed [qapm_pkg::MB_W-1:0] b,
  output logic signed [qapm_pkg::MP_W-1:0]      p_r
);
  import qapm_pkg::*;

  // both operands sign-extended to the full product width
  always_ff @(posedge clk) begin
    p_r <= MP_W'(a) * MP_W'(b);
  end

endmodule

`default_nettype wire

FILE: sv/qapm_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle
module qapm_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire qapm_pkg::div_req_t req,
  output qapm_pkg::div_rsp_t      rsp
);
  import qapm_pkg::*;

  logic              busy_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW:0]   rem_shift;
  logic              fits;

  // One shift-subtract step
  always_comb begin
    rem_shift = {rem_r, quo_r[DIV_NW-1]};
    fits      = rem_shift >= {1'b0, den_r};
    rem_nxt   = fits ? DIV_DW'(rem_shift - {1'b0, den_r}) : rem_shift[DIV_DW-1:0];
    quo_nxt   = {quo_r[DIV_NW-2:0], fits};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CW'(DIV_NW);
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

  // Operands
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (busy_r && cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done = busy_r && (cnt_r == '0);
  assign rsp.quot = quo_r;

endmodule

`default_nettype wire

FILE: sv/qapm_core.sv
`default_nettype none

// Sequencer and datapath: two PID passes, then the motor mixer
module qapm_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire qapm_pkg::cfg_t      cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire qapm_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output qapm_pkg::out_item_t      out_item
);
  import qapm_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_ERR   = 13'b0000000000010,
    S_P     = 13'b0000000000100,
    S_I     = 13'b0000000001000,
    S_DF    = 13'b0000000010000,
    S_DIV   = 13'b0000000100000,
    S_DWAIT = 13'b0000001000000,
    S_D     = 13'b0000010000000,
    S_SUM   = 13'b0000100000000,
    S_MIX   = 13'b0001000000000,
    S_MMUL  = 13'b0010000000000,
    S_MMAP  = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  localparam logic [1:0] MOT_LF = 2'd0;
  localparam logic [1:0] MOT_LB = 2'd3;

  localparam logic signed [ERR_W-1:0] IZONE_E  = ERR_W'(IZONE);
  localparam logic signed [ACC_W-1:0] PID_MAX_A = ACC_W'(PID_MAX);
  localparam logic signed [MIX_W-1:0] MOT_LO_M = MIX_W'(MOT_LO);
  localparam logic signed [MIX_W-1:0] MOT_HI_M = MIX_W'(MOT_HI);

  function automatic logic signed [ANG_W-1:0] sat16(input logic signed [ANG_W:0] v);
    if (v[ANG_W] != v[ANG_W-1]) begin
      return v[ANG_W] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
    end
    return v[ANG_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic signed [ANG_W-1:0]  cx_r, cy_r, dx_r, dy_r;
  logic [THR_W-1:0]         thr_r;
  logic [DT_W-1:0]          dt_r;
  logic                     axis_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [INT_W-1:0]  integ_x_r, integ_y_r;
  logic signed [ERR_W-1:0]  last_x_r, last_y_r;
  logic signed [PID_W-1:0]  pid_x_r, pid_y_r;
  logic signed [RATE_W-1:0] rate_r;
  logic                     rneg_r;
  logic [1:0]               mot_idx_r;
  logic [PWM_W-1:0]         v2_r;
  logic [MOT_W-1:0]         mot_r [4];
  out_item_t                out_r;
  logic                     out_valid_r;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [MP_W-1:0]   prod;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  logic signed [ANG_W-1:0]  cx_new, cy_new, cur_c, cur_d;
  logic signed [ERR_W-1:0]  err_new, cur_last;
  logic signed [INT_W-1:0]  cur_integ, integ_sat;
  logic [GAIN_W-1:0]        cur_kp, cur_ki, cur_kd;
  logic signed [MP_W-1:0]   p_trunc;
  logic signed [INT_W:0]    integ_sum;
  logic                     in_zone;
  logic signed [DIFF_W-1:0] diff;
  logic [MP_W-1:0]          prod_abs;
  logic signed [RATE_W-1:0] q_s;
  logic signed [ACC_W-1:0]  total;
  logic signed [PID_W-1:0]  pid_new;
  logic [PWM_W+1:0]         base_int;
  logic signed [MIX_W-1:0]  base_q, px_t, py_t, pwm, pwm_cl, pwm_int;
  logic [PWM_W-1:0]         w, w_off;
  logic [MP_W-1:0]          mot_scaled;
  logic                     load_out;

  // Shared units
  qapm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  qapm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Offset correction at input transfer
  assign cx_new = sat16((ANG_W+1)'(in_item.measured_angle_x) + (ANG_W+1)'(cfg.offset_x));
  assign cy_new = sat16((ANG_W+1)'(in_item.measured_angle_y) + (ANG_W+1)'(cfg.offset_y));

  // Per-axis selection
  assign cur_c     = axis_r ? cy_r : cx_r;
  assign cur_d     = axis_r ? dy_r : dx_r;
  assign cur_last  = axis_r ? last_y_r : last_x_r;
  assign cur_integ = axis_r ? integ_y_r : integ_x_r;
  assign cur_kp    = axis_r ? cfg.gain_p_y : cfg.gain_p_x;
  assign cur_ki    = axis_r ? cfg.gain_i_y : cfg.gain_i_x;
  assign cur_kd    = axis_r ? cfg.gain_d_y : cfg.gain_d_x;
  assign err_new   = ERR_W'(cur_c) - ERR_W'(cur_d);

  // PID arithmetic around the shared units
  always_comb begin
    p_trunc   = trunc_q(prod);
    in_zone   = (err_r > -IZONE_E) && (err_r < IZONE_E);
    integ_sum = (INT_W+1)'(cur_integ) + $signed(p_trunc[INT_W:0]);
    if (integ_sum[INT_W] != integ_sum[INT_W-1]) begin
      integ_sat = integ_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
    end else begin
      integ_sat = integ_sum[INT_W-1:0];
    end
    diff     = DIFF_W'(err_r) - DIFF_W'(cur_last);
    prod_abs = prod[MP_W-1] ? MP_W'(-prod) : prod;
    q_s      = RATE_W'(div_rsp.quot);
    total    = acc_r + ACC_W'(p_trunc);
    priority if (total > PID_MAX_A) begin
      pid_new = PID_W'(PID_MAX);
    end else if (total < -PID_MAX_A) begin
      pid_new = -PID_W'(PID_MAX);
    end else begin
      pid_new = total[PID_W-1:0];
    end
  end

  // Motor mix for the motor in turn
  always_comb begin
    base_int = (PWM_W+2)'(BASE_INT) + (PWM_W+2)'(thr_r) * (PWM_W+2)'(THR_GAIN);
    base_q   = MIX_W'({base_int, {FRAC_BITS{1'b0}}});
    px_t     = MIX_W'(pid_x_r);
    py_t     = MIX_W'(pid_y_r);
    pwm      = base_q
             + ((mot_idx_r == MOT_LF || mot_idx_r == MOT_LB) ? py_t : -py_t)
             + (mot_idx_r[1] ? px_t : -px_t);
    priority if (pwm < MOT_LO_M) begin
      pwm_cl = MOT_LO_M;
    end else if (pwm > MOT_HI_M) begin
      pwm_cl = MOT_HI_M;
    end else begin
      pwm_cl = pwm;
    end
    pwm_int    = pwm_cl >>> FRAC_BITS;
    w          = pwm_int[PWM_W-1:0];
    w_off      = w - PWM_W'(PWM_ZERO);
    mot_scaled = prod >> RECIP_SH;
  end

  // Multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_P: begin
        mul_a = MA_W'({1'b0, cur_kp});
        mul_b = MB_W'(err_r);
      end
      S_I: begin
        mul_a = MA_W'({1'b0, cur_ki});
        mul_b = MB_W'(err_r);
      end
      S_DF: begin
        mul_a = MA_W'(RATE_SCALE);
        mul_b = MB_W'(diff);
      end
      S_D: begin
        mul_a = MA_W'({1'b0, cur_kd});
        mul_b = rate_r;
      end
      S_MMUL: begin
        mul_a = MA_W'(RECIP);
        mul_b = MB_W'({1'b0, v2_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider request
  assign div_req.start = (state_r == S_DIV);
  assign div_req.num   = prod_abs[DIV_NW-1:0];
  assign div_req.den   = dt_r;

  assign in_ready = (state_r == S_IDLE);
  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_item.throttle > THR_W'(THR_MIN)) begin
          state_nxt = S_ERR;
        end
      end
      S_ERR:   state_nxt = S_P;
      S_P:     state_nxt = S_I;
      S_I:     state_nxt = S_DF;
      S_DF:    state_nxt = S_DIV;
      S_DIV:   state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (div_rsp.done) begin
          state_nxt = S_D;
        end
      end
      S_D:     state_nxt = S_SUM;
      S_SUM:   state_nxt = axis_r ? S_MIX : S_ERR;
      S_MIX:   state_nxt = S_MMUL;
      S_MMUL:  state_nxt = S_MMAP;
      S_MMAP:  state_nxt = (mot_idx_r == MOT_LB) ? S_OUT : S_MIX;
      S_OUT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      integ_x_r   <= '0;
      integ_y_r   <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      axis_r      <= 1'b0;
      mot_idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_IDLE) begin
        axis_r    <= 1'b0;
        mot_idx_r <= '0;
      end
      if (state_r == S_SUM) begin
        axis_r <= 1'b1;
      end
      if (state_r == S_MMAP) begin
        mot_idx_r <= mot_idx_r + 1'b1;
      end
      // integral only inside the zone
      if (state_r == S_DF && in_zone) begin
        if (axis_r) begin
          integ_y_r <= integ_sat;
        end else begin
          integ_x_r <= integ_sat;
        end
      end
      if (state_r == S_DIV) begin
        if (axis_r) begin
          last_y_r <= err_r;
        end else begin
          last_x_r <= err_r;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cx_r  <= cx_new;
          cy_r  <= cy_new;
          dx_r  <= in_item.desired_angle_x;
          dy_r  <= in_item.desired_angle_y;
          thr_r <= in_item.throttle;
          dt_r  <= (in_item.elapsed_ms == '0) ? DT_W'(1) : in_item.elapsed_ms;
        end
      end
      S_ERR:   err_r <= err_new;
      S_I:     acc_r <= ACC_W'(p_trunc);
      S_DIV: begin
        acc_r  <= acc_r + ACC_W'(cur_integ);
        rneg_r <= prod[MP_W-1];
      end
      S_DWAIT: begin
        if (div_rsp.done) begin
          rate_r <= rneg_r ? -q_s : q_s;
        end
      end
      S_SUM: begin
        if (axis_r) begin
          pid_y_r <= pid_new;
        end else begin
          pid_x_r <= pid_new;
        end
      end
      S_MIX:   v2_r <= {w_off[PWM_W-2:0], 1'b0};
      S_MMAP:  mot_r[mot_idx_r] <= mot_scaled[MOT_W-1:0] + MOT_W'(MOT_OFS);
      S_OUT: begin
        if (load_out) begin
          out_r.motor_left_front  <= mot_r[0];
          out_r.motor_right_front <= mot_r[1];
          out_r.motor_right_back  <= mot_r[2];
          out_r.motor_left_back   <= mot_r[3];
          out_r.corrected_angle_x <= cx_r;
          out_r.corrected_angle_y <= cy_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // A low-throttle transfer is dropped at once
  a_low_thr_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_item.throttle <= THR_W'(THR_MIN)) |=> state_r == S_IDLE)
    else $error("low-throttle item started a control step");

  // Divider completion only while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DWAIT)
    else $error("divider finished outside its wait step");

  // Integrators move only in the integral step
  a_integ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DF) |=> ($stable(integ_x_r) && $stable(integ_y_r)))
    else $error("integrator changed outside its update step");

  // Every result carries motor commands in range
  a_motor_range: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |->
      (out_r.motor_left_front >= MOT_W'(MOT_OFS) && out_r.motor_left_front <= 7'd100 &&
       out_r.motor_right_front >= MOT_W'(MOT_OFS) && out_r.motor_right_front <= 7'd100 &&
       out_r.motor_right_back >= MOT_W'(MOT_OFS) && out_r.motor_right_back <= 7'd100 &&
       out_r.motor_left_back >= MOT_W'(MOT_OFS) && out_r.motor_left_back <= 7'd100))
    else $error("motor command out of range");

endmodule

`default_nettype wire

FILE: sv/quad_attitude_pid_mixer_top.sv
// Two-axis attitude PID with a four-motor mixer.
// in_*: one transfer carries measured and desired X/Y angles (Q8.8 degrees),
// throttle percent and elapsed milliseconds. A transfer with throttle 15 or
// less is accepted while idle and produces nothing; all loop state holds.
// out_*: one transfer per controlled item with four motor commands (28..100)
// and the offset-corrected angles.
// cfg_*: register writes (offsets, P/I/D gains per axis), index as listed in
// the register map; issue them only while the block is idle.
// One item at a time: the next input is taken only after the result of the
// last one is loaded into the output register. Each axis waits on the
// 27-step restoring divider for the derivative rate and runs 7 sequencing
// steps around the shared multiplier; the mixer steps through mix, multiply
// and map for each motor.
// A finished result sits in the output register; the block takes and works
// on the next item meanwhile and waits at its end while out_tready is low.
// Reset (rst_n low, synchronous): integrators and last errors clear, gains
// and offsets return to their defaults, both channels go empty.
`default_nettype none

module quad_attitude_pid_mixer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // tdata: measured_angle_x[15:0], measured_angle_y[31:16],
  //   desired_angle_x[47:32], desired_angle_y[63:48], throttle[70:64],
  //   elapsed_ms[86:71], zero pad[87]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,
  // tdata: motor_left_front[6:0], motor_right_front[13:7],
  //   motor_right_back[20:14], motor_left_back[27:21],
  //   corrected_angle_x[43:28], corrected_angle_y[59:44], zero pad[63:60]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,
  // register write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import qapm_pkg::*;

  cfg_t      cfg_r;
  in_item_t  in_item;
  out_item_t out_item;

  // Register file
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_x <= '0;
      cfg_r.offset_y <= '0;
      cfg_r.gain_p_x <= GAIN_W'(GAIN_P_RESET);
      cfg_r.gain_i_x <= GAIN_W'(GAIN_I_RESET);
      cfg_r.gain_d_x <= GAIN_W'(GAIN_D_RESET);
      cfg_r.gain_p_y <= GAIN_W'(GAIN_P_RESET);
      cfg_r.gain_i_y <= GAIN_W'(GAIN_I_RESET);
      cfg_r.gain_d_y <= GAIN_W'(GAIN_D_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_OFFSET_X: cfg_r.offset_x <= cfg_data;
        REG_OFFSET_Y: cfg_r.offset_y <= cfg_data;
        REG_GAIN_P_X: cfg_r.gain_p_x <= cfg_data;
        REG_GAIN_I_X: cfg_r.gain_i_x <= cfg_data;
        REG_GAIN_D_X: cfg_r.gain_d_x <= cfg_data;
        REG_GAIN_P_Y: cfg_r.gain_p_y <= cfg_data;
        REG_GAIN_I_Y: cfg_r.gain_i_y <= cfg_data;
        REG_GAIN_D_Y: cfg_r.gain_d_y <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input unpacking
  assign in_item.measured_angle_x = in_tdata[15:0];
  assign in_item.measured_angle_y = in_tdata[31:16];
  assign in_item.desired_angle_x  = in_tdata[47:32];
  assign in_item.desired_angle_y  = in_tdata[63:48];
  assign in_item.throttle         = in_tdata[70:64];
  assign in_item.elapsed_ms       = in_tdata[86:71];

  qapm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  // Output packing
  assign out_tdata = {4'b0000,
                      out_item.corrected_angle_y,
                      out_item.corrected_angle_x,
                      out_item.motor_left_back,
                      out_item.motor_right_back,
                      out_item.motor_right_front,
                      out_item.motor_left_front};

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

import qapm_pkg::*;

// Tracks the attitude loop state and the motor commands each accepted sample must produce.
class motor_mix_board;
  logic signed [15:0] ofs_x, ofs_y;
  logic [15:0]        kp_x, ki_x, kd_x, kp_y, ki_y, kd_y;
  longint             integ_x, integ_y, last_err_x, last_err_y;
  out_item_t          motor_cmds_due[$];
  int                 errors;

  function new();
    ofs_x = '0;
    ofs_y = '0;
    kp_x = 16'd128;
    ki_x = 16'd0;
    kd_x = 16'd256;
    kp_y = 16'd128;
    ki_y = 16'd0;
    kd_y = 16'd256;
    integ_x = 0;
    integ_y = 0;
    last_err_x = 0;
    last_err_y = 0;
    errors = 0;
  endfunction

  function void set_reg(cfg_idx_t idx, logic [15:0] val);
    case (idx)
      REG_OFFSET_X: ofs_x = val;
      REG_OFFSET_Y: ofs_y = val;
      REG_GAIN_P_X: kp_x = val;
      REG_GAIN_I_X: ki_x = val;
      REG_GAIN_D_X: kd_x = val;
      REG_GAIN_P_Y: kp_y = val;
      REG_GAIN_I_Y: ki_y = val;
      REG_GAIN_D_Y: kd_y = val;
      default: ;
    endcase
  endfunction

  function longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // drop the fraction bits, rounding toward zero
  function longint drop_frac(longint v);
    return (v < 0) ? -((-v) >>> FRAC_BITS) : (v >>> FRAC_BITS);
  endfunction

  function longint axis_pid(longint err, longint kp, longint ki, longint kd,
                            inout longint integ, inout longint last_err,
                            input longint dt);
    longint one, p, rate, d;
    one = longint'(1) << FRAC_BITS;
    p = drop_frac(kp * err);
    // integrate only inside the +/-3 degree zone, saturating at 32 bits
    if (err > -3 * one && err < 3 * one)
      integ = clip(integ + drop_frac(ki * err), -64'sd2147483648, 64'sd2147483647);
    rate = ((err - last_err) * 1000) / dt;
    d = drop_frac(kd * rate);
    last_err = err;
    return clip(p + integ + d, -400 * one, 400 * one);
  endfunction

  // pulse width 1100..2000 mapped onto a 28..100 percent command
  function logic [6:0] motor_pct(longint pwm);
    longint one, w;
    one = longint'(1) << FRAC_BITS;
    w = clip(pwm, 1100 * one, 2000 * one) / one;
    return 7'((w - 1000) * 80 / 1000 + 20);
  endfunction

  function void note_input(in_item_t s);
    longint one, dt, cx, cy, px, py, base;
    out_item_t e;
    // low throttle: no output, loop state holds
    if (s.throttle <= 7'd15)
      return;
    one = longint'(1) << FRAC_BITS;
    dt = (s.elapsed_ms == 0) ? 1 : longint'(s.elapsed_ms);
    cx = clip(longint'($signed(s.measured_angle_x)) + longint'(ofs_x), -32768, 32767);
    cy = clip(longint'($signed(s.measured_angle_y)) + longint'(ofs_y), -32768, 32767);
    px = axis_pid(cx - longint'($signed(s.desired_angle_x)), longint'(kp_x),
                  longint'(ki_x), longint'(kd_x), integ_x, last_err_x, dt);
    py = axis_pid(cy - longint'($signed(s.desired_angle_y)), longint'(kp_y),
                  longint'(ki_y), longint'(kd_y), integ_y, last_err_y, dt);
    base = (1115 + 10 * longint'(s.throttle)) * one;
    e.motor_left_front  = motor_pct(base + py - px);
    e.motor_right_front = motor_pct(base - py - px);
    e.motor_right_back  = motor_pct(base - py + px);
    e.motor_left_back   = motor_pct(base + py + px);
    e.corrected_angle_x = 16'(cx);
    e.corrected_angle_y = 16'(cy);
    motor_cmds_due.push_back(e);
  endfunction

  function void check_result(logic [63:0] raw);
    out_item_t e;
    int        want[6];
    int        got[6];
    string     field[6];
    field = '{"motor_left_front", "motor_right_front", "motor_right_back",
              "motor_left_back", "corrected_angle_x", "corrected_angle_y"};
    if (motor_cmds_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: motor command with none outstanding, data %h", $time, raw);
      return;
    end
    e = motor_cmds_due.pop_front();
    want = '{int'(e.motor_left_front), int'(e.motor_right_front),
             int'(e.motor_right_back), int'(e.motor_left_back),
             int'($signed(e.corrected_angle_x)), int'($signed(e.corrected_angle_y))};
    got = '{int'(raw[6:0]), int'(raw[13:7]), int'(raw[20:14]), int'(raw[27:21]),
            int'($signed(raw[43:28])), int'($signed(raw[59:44]))};
    for (int i = 0; i < 6; i++) begin
      if (want[i] != got[i]) begin
        errors++;
        if (errors <= 10)
          $display("%0t: %s expected %0d, got %0d", $time, field[i], want[i], got[i]);
      end
    end
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int LONG_HOLD   = 600;
  localparam int SAT_STEPS   = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  motor_mix_board board;
  in_item_t       seen;
  bit             send_idle = 1'b1;
  bit             recv_idle = 1'b1;
  bit             hold_off = 1'b0;
  int             cycle_count = 0;

  quad_attitude_pid_mixer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("quad_attitude_pid_mixer_top: mismatch");
      $finish;
    end
  end

  // transfer monitor on both streams
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      seen.measured_angle_x = in_tdata[15:0];
      seen.measured_angle_y = in_tdata[31:16];
      seen.desired_angle_x  = in_tdata[47:32];
      seen.desired_angle_y  = in_tdata[63:48];
      seen.throttle         = in_tdata[70:64];
      seen.elapsed_ms       = in_tdata[86:71];
      board.note_input(seen);
    end
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata);
  end

  // result sink: random stall per transfer when idling, one long hold on request
  initial begin
    int stall;
    forever begin
      stall = recv_idle ? $urandom_range(0, 7) : 0;
      if (hold_off) begin
        stall = LONG_HOLD;
        hold_off = 1'b0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  function automatic in_item_t make_sample(input int mx, my, dx, dy, thr, dt);
    in_item_t s;
    s.measured_angle_x = 16'(mx);
    s.measured_angle_y = 16'(my);
    s.desired_angle_x  = 16'(dx);
    s.desired_angle_y  = 16'(dy);
    s.throttle         = 7'(thr);
    s.elapsed_ms       = 16'(dt);
    return s;
  endfunction

  function automatic int any_angle();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // most samples hover near the setpoint so the integral zone gets exercised
  function automatic in_item_t random_sample();
    int mx, my, dx, dy, thr, dt, pick;
    pick = $urandom_range(0, 99);
    if (pick < 12)
      thr = $urandom_range(0, 15);
    else if (pick < 25)
      thr = $urandom_range(101, 127);
    else
      thr = $urandom_range(16, 100);
    pick = $urandom_range(0, 99);
    if (pick < 10)
      dt = 0;
    else if (pick < 70)
      dt = $urandom_range(1, 40);
    else
      dt = $urandom_range(0, 65535);
    dx = any_angle();
    dy = any_angle();
    if ($urandom_range(0, 99) < 55) begin
      mx = dx - int'(board.ofs_x) + int'($urandom_range(0, 1800)) - 900;
      my = dy - int'(board.ofs_y) + int'($urandom_range(0, 1800)) - 900;
      mx = (mx > 32767) ? 32767 : ((mx < -32768) ? -32768 : mx);
      my = (my > 32767) ? 32767 : ((my < -32768) ? -32768 : my);
    end else begin
      mx = any_angle();
      my = any_angle();
    end
    return make_sample(mx, my, dx, dy, thr, dt);
  endfunction

  // offer one sample and wait for its transfer; valid stays high into the next one
  task automatic send_item(input in_item_t s);
    int gap;
    gap = send_idle ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, s.elapsed_ms, s.throttle, s.desired_angle_y, s.desired_angle_x,
                  s.measured_angle_y, s.measured_angle_x};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic stop_stream();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // wait for outstanding commands, then let a trailing low-throttle sample finish
  task automatic drain_results();
    for (int k = 0; k < 20000 && board.motor_cmds_due.size() != 0; k++)
      @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(input logic [15:0] ox, oy, kpx, kix, kdx, kpy, kiy, kdy);
    logic [15:0] vals [8];
    vals = '{ox, oy, kpx, kix, kdx, kpy, kiy, kdy};
    for (int i = 0; i < 8; i++)
      write_reg(cfg_idx_t'(i), vals[i]);
  endtask

  task automatic run_random(input int count, input bit idle, input bit long_hold);
    send_idle = idle;
    recv_idle = idle;
    for (int i = 0; i < count; i++) begin
      if (long_hold && i == count / 3)
        hold_off = 1'b1;
      send_item(random_sample());
    end
    stop_stream();
    drain_results();
  endtask

  initial begin
    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset gains, throttle edges, elapsed time edges, largest errors
    send_item(make_sample(0, 0, 0, 0, 50, 10));
    send_item(make_sample(30000, -30000, 0, 0, 15, 5));
    send_item(make_sample(256, -256, 0, 0, 16, 3));
    send_item(make_sample(-1000, 1000, 0, 0, 0, 0));
    send_item(make_sample(512, 512, 0, 0, 100, 0));
    send_item(make_sample(32767, -32768, -32768, 32767, 127, 65535));
    send_item(make_sample(-32768, 32767, 32767, -32768, 101, 1));
    stop_stream();
    drain_results();

    // corrected angle saturation in both directions
    write_reg(REG_OFFSET_X, 16'h7FFF);
    write_reg(REG_OFFSET_Y, 16'h8000);
    write_reg(REG_GAIN_I_X, 16'd512);
    write_reg(REG_GAIN_I_Y, 16'd512);
    send_item(make_sample(32767, -32768, 0, 0, 60, 20));
    send_item(make_sample(-32768, 32767, 0, 0, 60, 20));
    stop_stream();
    drain_results();

    // integral zone edges; each axis tests only its own error
    write_reg(REG_OFFSET_X, 16'h0000);
    write_reg(REG_OFFSET_Y, 16'h0000);
    send_item(make_sample(767, -767, 0, 0, 40, 10));
    send_item(make_sample(768, -768, 0, 0, 40, 10));
    send_item(make_sample(-767, 767, 0, 0, 40, 10));
    send_item(make_sample(100, 20000, 0, 0, 40, 10));
    send_item(make_sample(20000, 100, 0, 0, 40, 10));
    send_item(make_sample(-300, 300, 0, 0, 70, 0));
    send_item(make_sample(700, -700, 0, 0, 15, 2));
    send_item(make_sample(0, 0, 0, 0, 16, 65535));
    stop_stream();
    drain_results();

    // moderate gains
    load_regs(16'($urandom_range(0, 511) - 256), 16'($urandom_range(0, 511) - 256),
              16'($urandom_range(128, 1024)), 16'($urandom_range(1, 256)),
              16'($urandom_range(0, 512)), 16'($urandom_range(128, 1024)),
              16'($urandom_range(1, 256)), 16'($urandom_range(0, 512)));
    run_random(250, 1'b1, 1'b0);

    // largest offsets and gains
    load_regs(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(200, 1'b1, 1'b0);

    // all gains zero, offsets the other way
    load_regs(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_random(150, 1'b1, 1'b0);

    // arbitrary register values, back-to-back, with a long sink hold
    load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(320, 1'b0, 1'b1);

    // moderate gains again with heavy integral, idling and a long hold
    load_regs(16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
              16'($urandom_range(0, 2048)), 16'($urandom_range(1024, 8192)),
              16'($urandom_range(0, 1024)), 16'($urandom_range(0, 2048)),
              16'($urandom_range(1024, 8192)), 16'($urandom_range(0, 1024)));
    run_random(320, 1'b1, 1'b1);

    // push integral_x up and integral_y down at the fastest in-zone rate
    load_regs(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    for (int i = 0; i < SAT_STEPS; i++) begin
      int dx, dy;
      dx = int'($urandom_range(0, 20000)) - 10000;
      dy = int'($urandom_range(0, 20000)) - 10000;
      send_item(make_sample(dx + 767, dy - 767, dx, dy, $urandom_range(16, 100), 1));
    end
    stop_stream();
    drain_results();

    // wound-up integrators against arbitrary gains
    load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(60, 1'b1, 1'b0);

    if (board.errors == 0 && board.motor_cmds_due.size() == 0)
      $display("quad_attitude_pid_mixer_top: match");
    else
      $display("quad_attitude_pid_mixer_top: mismatch");
    $finish;
  end

endmodule

FILE: files.f
sv/qapm_pkg.sv
sv/qapm_mul.sv
sv/qapm_div.sv
sv/qapm_core.sv
sv/quad_attitude_pid_mixer_top.sv
dv/tb_top.sv
